@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; each macro takes clock, reset and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MBFL_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBFL_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mbfl_pkg.sv @@
// types and constants for the modbus rtu frame length detector
// no dependencies; imported by every module of the block
package mbfl_pkg;

  localparam int OFS_W = 10;
  localparam int LEN_W = 17;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic       start_of_frame;
    logic [7:0] rx_byte;
  } mbfl_in_t;

  typedef struct packed {
    logic       is_candidate;
    logic [8:0] frame_length;
    logic       length_overflow;
  } mbfl_res_t;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_WALK,
    PHASE_DONE
  } devid_phase_t;

  typedef struct packed {
    logic [7:0]       function_code;
    logic [7:0]       byte_two;
    logic [7:0]       byte_three;
    logic [7:0]       byte_six;
    logic [7:0]       byte_ten;
    logic [7:0]       objects_left;
    logic [OFS_W-1:0] next_header_offset;
    devid_phase_t     devid_phase;
    logic             overflow_flag;
  } mbfl_hdr_t;

  // function codes
  localparam int FC_EXC_BIT = 7;
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT     = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REG      = 8'd6;
  localparam logic [7:0] FC_READ_EXC_STAT  = 8'd7;
  localparam logic [7:0] FC_DIAG           = 8'd8;
  localparam logic [7:0] FC_EVT_COUNTER    = 8'd11;
  localparam logic [7:0] FC_EVT_LOG        = 8'd12;
  localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS     = 8'd16;
  localparam logic [7:0] FC_REPORT_ID      = 8'd17;
  localparam logic [7:0] FC_READ_FILE      = 8'd20;
  localparam logic [7:0] FC_WRITE_FILE     = 8'd21;
  localparam logic [7:0] FC_MASK_WRITE     = 8'd22;
  localparam logic [7:0] FC_RW_REGS        = 8'd23;
  localparam logic [7:0] FC_READ_FIFO      = 8'd24;
  localparam logic [7:0] FC_ENCAP          = 8'd43;
  localparam logic [7:0] MEI_DEVICE_ID     = 8'd14;

  // byte positions within a frame
  localparam len_t POS_FC       = len_t'(1);
  localparam len_t POS_B2       = len_t'(2);
  localparam len_t POS_B3       = len_t'(3);
  localparam len_t POS_B6       = len_t'(6);
  localparam len_t POS_OBJ_CNT  = len_t'(7);
  localparam len_t POS_B10      = len_t'(10);
  localparam logic [OFS_W-1:0] OFS_FIRST = OFS_W'(8);
  localparam logic [OFS_W:0]   OFS_SAT   = (OFS_W+1)'(1023);

endpackage

@@ hdl/mbfl_frame_state.sv @@
// per-frame state: byte count, captured header bytes, device-id object walk
// depends on mbfl_pkg
module mbfl_frame_state import mbfl_pkg::*; #(
  parameter int MAX_FRAME_LEN = 256,
  localparam int CW = $clog2(MAX_FRAME_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  mbfl_in_t      rx,
  output mbfl_hdr_t     hdr_next,
  output logic [CW-1:0] count_next
);

  mbfl_hdr_t        hdr;
  logic [CW-1:0]    count;
  mbfl_hdr_t        base_hdr;
  logic [CW-1:0]    base_cnt;
  len_t             idx;
  logic [OFS_W:0]   ofs_sum;
  logic [7:0]       obj_dec;

  always_comb begin
    base_hdr   = rx.start_of_frame ? '0 : hdr;
    base_cnt   = rx.start_of_frame ? '0 : count;
    hdr_next   = base_hdr;
    count_next = base_cnt;
    idx        = len_t'(base_cnt);
    ofs_sum    = {1'b0, base_hdr.next_header_offset} + (OFS_W+1)'(2)
                 + (OFS_W+1)'(rx.rx_byte);
    obj_dec    = base_hdr.objects_left - 8'd1;
    if (base_cnt >= CW'(MAX_FRAME_LEN)) begin
      hdr_next.overflow_flag = 1'b1;
    end else begin
      count_next = base_cnt + CW'(1);
      if (idx == POS_FC)  hdr_next.function_code = rx.rx_byte;
      if (idx == POS_B2)  hdr_next.byte_two      = rx.rx_byte;
      if (idx == POS_B3)  hdr_next.byte_three    = rx.rx_byte;
      if (idx == POS_B6)  hdr_next.byte_six      = rx.rx_byte;
      if (idx == POS_B10) hdr_next.byte_ten      = rx.rx_byte;
      if (idx == POS_OBJ_CNT) begin
        hdr_next.objects_left       = rx.rx_byte;
        hdr_next.next_header_offset = OFS_FIRST;
        hdr_next.devid_phase        = (rx.rx_byte == 8'd0) ? PHASE_DONE : PHASE_WALK;
      end else if (base_hdr.devid_phase == PHASE_WALK &&
                   idx == len_t'(base_hdr.next_header_offset) + len_t'(1)) begin
        // this byte is an object length: skip id, length and value bytes
        hdr_next.next_header_offset = (ofs_sum > OFS_SAT) ? OFS_SAT[OFS_W-1:0]
                                                          : ofs_sum[OFS_W-1:0];
        hdr_next.objects_left = obj_dec;
        if (obj_dec == 8'd0) hdr_next.devid_phase = PHASE_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr   <= '0;
      count <= '0;
    end else if (take) begin
      hdr   <= hdr_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/mbfl_len_check.sv @@
// function-code length rules: decides whether the bytes so far form a frame
// depends on mbfl_pkg
module mbfl_len_check import mbfl_pkg::*; #(
  parameter int MAX_FRAME_LEN = 256,
  localparam int CW = $clog2(MAX_FRAME_LEN + 1)
) (
  input  mbfl_hdr_t     hdr,
  input  logic [CW-1:0] count,
  output mbfl_res_t     res
);

  len_t        c;
  len_t        b2_len;
  logic        have2;
  logic        diag_ok;
  logic        match;
  logic [15:0] sub;

  always_comb begin
    c       = len_t'(count);
    b2_len  = len_t'(hdr.byte_two) + len_t'(5);
    have2   = c >= len_t'(3);
    sub     = {hdr.byte_two, hdr.byte_three};
    diag_ok = (sub >= 16'd1 && sub <= 16'd4) || (sub >= 16'd10 && sub <= 16'd18) ||
              sub == 16'd20;
    match   = 1'b0;
    if (c < len_t'(2)) begin
      match = 1'b0;
    end else if (hdr.function_code[FC_EXC_BIT]) begin
      match = c == len_t'(5);
    end else begin
      case (hdr.function_code)
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
          match = c == len_t'(8) || (have2 && c == b2_len);
        end
        FC_WRITE_COIL, FC_WRITE_REG: begin
          match = c == len_t'(8);
        end
        FC_READ_EXC_STAT: begin
          match = c == len_t'(4) || c == len_t'(5);
        end
        FC_DIAG: begin
          match = c >= len_t'(4) && diag_ok && c == len_t'(8);
        end
        FC_EVT_COUNTER: begin
          match = c == len_t'(4) || c == len_t'(8);
        end
        FC_EVT_LOG, FC_REPORT_ID: begin
          match = c == len_t'(4) || (have2 && c == b2_len);
        end
        FC_WRITE_COILS, FC_WRITE_REGS: begin
          match = c == len_t'(8) ||
                  (c >= len_t'(7) && c == len_t'(hdr.byte_six) + len_t'(9));
        end
        FC_READ_FILE, FC_WRITE_FILE: begin
          match = have2 && c == b2_len;
        end
        FC_MASK_WRITE: begin
          match = c == len_t'(10);
        end
        FC_RW_REGS: begin
          match = (have2 && c == b2_len) ||
                  (c >= len_t'(11) && c == len_t'(hdr.byte_ten) + len_t'(13));
        end
        FC_READ_FIFO: begin
          match = c == len_t'(6) || (c >= len_t'(4) && c == len_t'(sub) + len_t'(6));
        end
        FC_ENCAP: begin
          // device id: fixed 7-byte request, or end of object list plus crc
          if (have2 && hdr.byte_two == MEI_DEVICE_ID) begin
            match = c == len_t'(7) ||
                    (c >= len_t'(8) && hdr.devid_phase == PHASE_DONE &&
                     c == len_t'(hdr.next_header_offset) + len_t'(2));
          end
        end
        default: begin
          match = 1'b0;
        end
      endcase
    end
    res.is_candidate    = !hdr.overflow_flag && match;
    res.frame_length    = 9'(count);
    res.length_overflow = hdr.overflow_flag;
  end

endmodule

@@ hdl/mbfl_skid.sv @@
// two-entry output buffer: result register plus skid register
// depends on mbfl_pkg
module mbfl_skid import mbfl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mbfl_res_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mbfl_res_t out_data
);

  logic      skid_valid;
  mbfl_res_t skid_data;
  logic      stalled;

  assign in_ready = !skid_valid;
  assign stalled  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (stalled) begin
      if (in_valid && in_ready) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stalled) begin
      if (in_valid && in_ready) skid_data <= in_data;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

@@ hdl/modbus_rtu_frame_length_detector.sv @@
// modbus rtu frame length detector, top level
// an accepted byte's result is registered in the result register, or in the skid register
// while the output stalls; throughput: one byte per cycle while the skid register is empty;
// the per-byte state update and length compare sit in one combinational pass ahead of
// the result register; a two-entry output buffer keeps accepting while one result waits
// reset (rst, synchronous) clears the frame state and empties the output
module modbus_rtu_frame_length_detector import mbfl_pkg::*; #(
  parameter int MAX_FRAME_LEN = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_ready,
  input  mbfl_in_t  rx_data,
  output logic      res_valid,
  input  logic      res_ready,
  output mbfl_res_t res_data
);

  localparam int CW = $clog2(MAX_FRAME_LEN + 1);

  logic          take;
  mbfl_hdr_t     hdr_next;
  logic [CW-1:0] count_next;
  mbfl_res_t     res_next;

  assign take = rx_valid && rx_ready;

  mbfl_frame_state #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_state (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx         (rx_data),
    .hdr_next   (hdr_next),
    .count_next (count_next)
  );

  mbfl_len_check #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_check (
    .hdr   (hdr_next),
    .count (count_next),
    .res   (res_next)
  );

  mbfl_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx_valid),
    .in_ready  (rx_ready),
    .in_data   (res_next),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_data  (res_data)
  );

endmodule

@@ hdl/mbfl_checker.sv @@
// port-level checks for the frame length detector, bound to the top level
// depends on mbfl_pkg and assert_macros.svh
`include "assert_macros.svh"

module mbfl_checker import mbfl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      rx_ready,
  input logic      res_valid,
  input logic      res_ready,
  input mbfl_res_t res_data
);

  `MBFL_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result changed")
  `MBFL_ASSERT_IMP(a_ovf_no_cand, clk, rst, res_valid && res_data.length_overflow, !res_data.is_candidate, "candidate during overflow")
  `MBFL_ASSERT_IMP(a_ready_low, clk, rst, !rx_ready, res_valid, "input blocked with no result pending")
  `MBFL_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !res_valid, "result valid after reset")

endmodule

bind modbus_rtu_frame_length_detector mbfl_checker u_mbfl_checker (.*);

@@ dv/tb_modbus_rtu_frame_length_detector.sv @@
// testbench for modbus_rtu_frame_length_detector: directed and random rtu frames, a
// per-byte frame status predictor and an in-order result check; needs mbfl_pkg and the rtl
module tb_modbus_rtu_frame_length_detector;
  import mbfl_pkg::*;

  localparam int MAX_LEN = 256;
  localparam int RANDOM_ITEMS = 330;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN = 80;
  localparam int DRAIN_TAIL = 8;
  localparam int MAX_PRINTS = 30;

  // diagnostic subfunctions with a fixed-length echo
  localparam int DSUB_A_LO = 1;
  localparam int DSUB_A_HI = 4;
  localparam int DSUB_B_LO = 10;
  localparam int DSUB_B_HI = 18;
  localparam int DSUB_BUS_MSG = 20;

  typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_ready;
  mbfl_in_t  rx_data = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  mbfl_res_t res_data;

  modbus_rtu_frame_length_detector #(.MAX_FRAME_LEN(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_data  (rx_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state for the frame in progress
  int unsigned  rx_count;
  logic [7:0]   cur_fc;
  logic [7:0]   cur_b2;
  logic [7:0]   cur_b3;
  logic [7:0]   cur_b6;
  logic [7:0]   cur_b10;
  logic [7:0]   objs_left;
  int unsigned  hdr_ofs;
  devid_phase_t walk_phase;
  logic         ovf_seen;

  mbfl_res_t   status_q[$];
  logic [7:0]  frame_buf[$];
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;
  bit          sender_gaps = 1'b0;
  sink_mode_t  sink_mode = SINK_ALWAYS;

  logic [7:0] known_codes [0:18] = '{
    FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_COIL,
    FC_WRITE_REG, FC_READ_EXC_STAT, FC_DIAG, FC_EVT_COUNTER, FC_EVT_LOG,
    FC_WRITE_COILS, FC_WRITE_REGS, FC_REPORT_ID, FC_READ_FILE, FC_WRITE_FILE,
    FC_MASK_WRITE, FC_RW_REGS, FC_READ_FIFO, FC_ENCAP
  };

  function automatic void start_new_frame();
    rx_count = 0;
    cur_fc = '0;
    cur_b2 = '0;
    cur_b3 = '0;
    cur_b6 = '0;
    cur_b10 = '0;
    objs_left = '0;
    hdr_ofs = 0;
    walk_phase = PHASE_IDLE;
    ovf_seen = 1'b0;
  endfunction

  function automatic bit diag_sub_fixed(logic [15:0] sub);
    return (sub >= DSUB_A_LO && sub <= DSUB_A_HI) || (sub >= DSUB_B_LO && sub <= DSUB_B_HI) ||
           sub == DSUB_BUS_MSG;
  endfunction

  function automatic bit frame_complete(int unsigned c);
    bit have2;
    have2 = c >= 3;
    if (c < 2) return 1'b0;
    if (cur_fc[FC_EXC_BIT]) return c == 5;
    case (cur_fc)
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT:
        return c == 8 || (have2 && c == 5 + cur_b2);
      FC_WRITE_COIL, FC_WRITE_REG: return c == 8;
      FC_READ_EXC_STAT: return c == 4 || c == 5;
      FC_DIAG: begin
        if (c < 4) return 1'b0;
        return diag_sub_fixed({cur_b2, cur_b3}) && c == 8;
      end
      FC_EVT_COUNTER: return c == 4 || c == 8;
      FC_EVT_LOG, FC_REPORT_ID: return c == 4 || (have2 && c == 5 + cur_b2);
      FC_WRITE_COILS, FC_WRITE_REGS: return c == 8 || (c >= 7 && c == 9 + cur_b6);
      FC_READ_FILE, FC_WRITE_FILE: return have2 && c == 5 + cur_b2;
      FC_MASK_WRITE: return c == 10;
      FC_RW_REGS: return (have2 && c == 5 + cur_b2) || (c >= 11 && c == 13 + cur_b10);
      FC_READ_FIFO: return c == 6 || (c >= 4 && c == 6 + {cur_b2, cur_b3});
      FC_ENCAP: begin
        if (!have2 || cur_b2 != MEI_DEVICE_ID) return 1'b0;
        if (c == 7) return 1'b1;
        if (c < 8) return 1'b0;
        return walk_phase == PHASE_DONE && c == hdr_ofs + 2;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void capture_byte(int unsigned idx, logic [7:0] b);
    int unsigned nxt;
    if (idx == POS_FC) cur_fc = b;
    else if (idx == POS_B2) cur_b2 = b;
    else if (idx == POS_B3) cur_b3 = b;
    else if (idx == POS_B6) cur_b6 = b;
    else if (idx == POS_B10) cur_b10 = b;
    if (idx == POS_OBJ_CNT) begin
      objs_left = b;
      hdr_ofs = OFS_FIRST;
      walk_phase = (b == 8'd0) ? PHASE_DONE : PHASE_WALK;
    end else if (walk_phase == PHASE_WALK && idx == hdr_ofs + 1) begin
      // object length byte: jump to the next object header
      nxt = hdr_ofs + 2 + b;
      hdr_ofs = (nxt > OFS_SAT) ? OFS_SAT : nxt;
      objs_left = objs_left - 8'd1;
      if (objs_left == 8'd0) walk_phase = PHASE_DONE;
    end
  endfunction

  function automatic mbfl_res_t predict_frame_status(mbfl_in_t it);
    mbfl_res_t r;
    if (it.start_of_frame) start_new_frame();
    if (rx_count >= MAX_LEN) begin
      ovf_seen = 1'b1;
    end else begin
      capture_byte(rx_count, it.rx_byte);
      rx_count++;
    end
    r.is_candidate = !ovf_seen && frame_complete(rx_count);
    r.frame_length = 9'(rx_count);
    r.length_overflow = ovf_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
  endtask

  // predict on every byte transaction, check every result transaction in order
  always @(posedge clk) begin
    mbfl_res_t want;
    cycle_cnt++;
    if (!rst && rx_valid && rx_ready) status_q.push_back(predict_frame_status(rx_data));
    if (!rst && res_valid && res_ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected result, frame_length", res_data.frame_length, 0);
      end else begin
        want = status_q.pop_front();
        if (res_data.is_candidate !== want.is_candidate)
          report_mismatch("is_candidate", res_data.is_candidate, want.is_candidate);
        if (res_data.frame_length !== want.frame_length)
          report_mismatch("frame_length", res_data.frame_length, want.frame_length);
        if (res_data.length_overflow !== want.length_overflow)
          report_mismatch("length_overflow", res_data.length_overflow, want.length_overflow);
      end
    end
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", status_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: long hold-off on request, otherwise the current stall pattern
  initial begin : result_sink
    int unsigned pat_cnt;
    pat_cnt = 0;
    forever begin
      @(posedge clk);
      pat_cnt++;
      if (rst) begin
        res_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        res_ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: res_ready <= 1'b1;
          SINK_RANDOM: res_ready <= ($urandom_range(0, 2) != 0);
          default:     res_ready <= (pat_cnt % 7) >= 3;
        endcase
      end
    end
  end

  task automatic send_byte(input logic sof, input logic [7:0] b);
    int unsigned gap;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    rx_valid <= 1'b1;
    rx_data <= mbfl_in_t'({sof, b});
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
  endtask

  task automatic send_buffer(input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes && i < frame_buf.size(); i++)
      send_byte(i == 0, frame_buf[i]);
  endtask

  function automatic int unsigned pick_size();
    if ($urandom_range(0, 39) == 0) return $urandom_range(13, 250);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] pick_diag_sub();
    int unsigned r;
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 13);
    if (r <= 3) return 16'(DSUB_A_LO + r);
    if (r <= 12) return 16'(DSUB_B_LO + r - 4);
    return 16'(DSUB_BUS_MSG);
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return {1'b1, 7'($urandom)};
    if (r == 1) return 8'($urandom_range(0, 127));
    return known_codes[$urandom_range(0, 18)];
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endfunction

  // frame with random content, well-formed for known and exception codes; crc bytes are random filler
  function automatic void build_frame(logic [7:0] code);
    int unsigned n;
    int unsigned total;
    int unsigned k;
    bit req;
    logic [15:0] sub;
    frame_buf.delete();
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(code);
    req = $urandom_range(0, 1);
    total = 0;
    if (code[FC_EXC_BIT]) begin
      total = 5;
    end else begin
      case (code)
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
        FC_EVT_LOG, FC_REPORT_ID: begin
          if (req) begin
            total = (code == FC_EVT_LOG || code == FC_REPORT_ID) ? 4 : 8;
          end else begin
            n = pick_size();
            frame_buf.push_back(8'(n));
            total = 5 + n;
          end
        end
        FC_WRITE_COIL, FC_WRITE_REG: total = 8;
        FC_READ_EXC_STAT: total = $urandom_range(4, 5);
        FC_EVT_COUNTER: total = req ? 4 : 8;
        FC_MASK_WRITE: total = 10;
        FC_DIAG: begin
          sub = pick_diag_sub();
          frame_buf.push_back(sub[15:8]);
          frame_buf.push_back(sub[7:0]);
          total = 8;
        end
        FC_WRITE_COILS, FC_WRITE_REGS: begin
          if (req) begin
            push_random(4);
            n = pick_size();
            frame_buf.push_back(8'(n));
            total = 9 + n;
          end else begin
            total = 8;
          end
        end
        FC_READ_FILE, FC_WRITE_FILE: begin
          n = pick_size();
          frame_buf.push_back(8'(n));
          total = 5 + n;
        end
        FC_RW_REGS: begin
          n = pick_size();
          if (req) begin
            push_random(8);
            frame_buf.push_back(8'(n));
            total = 13 + n;
          end else begin
            frame_buf.push_back(8'(n));
            total = 5 + n;
          end
        end
        FC_READ_FIFO: begin
          if (req) begin
            total = 6;
          end else begin
            n = pick_size();
            frame_buf.push_back(8'(n >> 8));
            frame_buf.push_back(8'(n));
            total = 6 + n;
          end
        end
        FC_ENCAP: begin
          frame_buf.push_back(($urandom_range(0, 9) != 0) ? MEI_DEVICE_ID : 8'($urandom));
          push_random(4);
          k = $urandom_range(0, 3);
          frame_buf.push_back(8'(k));
          repeat (k) begin
            n = $urandom_range(0, 6);
            frame_buf.push_back(8'($urandom));
            frame_buf.push_back(8'(n));
            push_random(n);
          end
          total = frame_buf.size() + 2;
        end
        default: total = $urandom_range(2, 12);
      endcase
    end
    while (frame_buf.size() < total) frame_buf.push_back(8'($urandom));
  endfunction

  task automatic test_continuation_after_reset();
    // no start marker yet: the first byte still counts as the address
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, FC_READ_HOLDING);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
  endtask

  task automatic test_short_and_exception();
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h00);
    frame_buf = {8'h01, 8'h83, 8'h02, 8'hC0, 8'hF1};
    send_buffer(frame_buf.size());
    frame_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(frame_buf.size());
  endtask

  task automatic test_function_code_sweep();
    for (int i = 0; i < 19; i++) begin
      build_frame(known_codes[i]);
      send_buffer(frame_buf.size());
    end
  endtask

  task automatic test_diag_subfunctions();
    frame_buf = {8'h01, FC_DIAG, 8'h00, 8'(DSUB_BUS_MSG), 8'h00, 8'h00, 8'h12, 8'h34};
    send_buffer(frame_buf.size());
    frame_buf = {8'h01, FC_DIAG, 8'h00, 8'(DSUB_BUS_MSG - 1), 8'h00, 8'h00, 8'h12, 8'h34};
    send_buffer(frame_buf.size());
    frame_buf = {8'h01, FC_DIAG, 8'h01, 8'(DSUB_A_LO), 8'h00, 8'h00, 8'h12, 8'h34};
    send_buffer(frame_buf.size());
  endtask

  task automatic test_device_id_walk();
    // two objects, then an empty list, then a non device-id mei type
    frame_buf = {8'h01, FC_ENCAP, MEI_DEVICE_ID, 8'h01, 8'h01, 8'h00, 8'h00, 8'h02,
                 8'h00, 8'h03, 8'h41, 8'h42, 8'h43, 8'h01, 8'h02, 8'h44, 8'h45,
                 8'hAA, 8'h55};
    send_buffer(frame_buf.size());
    frame_buf = {8'h01, FC_ENCAP, MEI_DEVICE_ID, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
                 8'hAA, 8'h55};
    send_buffer(frame_buf.size());
    frame_buf = {8'h01, FC_ENCAP, 8'h0D, 8'h01, 8'h01, 8'h00, 8'h00};
    send_buffer(frame_buf.size());
  endtask

  task automatic test_huge_object_overflow();
    // a 255-byte object pushes the next header out of reach, then the frame overflows
    frame_buf = {8'h01, FC_ENCAP, MEI_DEVICE_ID, 8'h01, 8'h01, 8'h00, 8'h00, 8'h03,
                 8'h00, 8'hFF};
    push_random(MAX_LEN + 3 - frame_buf.size());
    send_buffer(frame_buf.size());
    build_frame(FC_WRITE_COIL);
    send_buffer(frame_buf.size());
  endtask

  task automatic test_backpressure();
    sink_mode = SINK_ALWAYS;
    sender_gaps = 1'b0;
    hold_cycles = HOLD_LEN;
    repeat (4) begin
      build_frame(FC_READ_HOLDING);
      send_buffer(frame_buf.size());
    end
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned nb;
    int unsigned r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: loose bytes with random start markers
        nb = $urandom_range(1, 6);
        repeat (nb) send_byte(1'($urandom), 8'($urandom));
      end else begin
        build_frame(pick_code());
        r = $urandom_range(0, 9);
        nb = frame_buf.size();
        if (r == 0) nb = $urandom_range(1, frame_buf.size());
        else if (r == 1) begin
          push_random($urandom_range(1, 3));
          nb = frame_buf.size();
        end
        send_buffer(nb);
      end
      sent += nb;
    end
  endtask

  initial begin
    start_new_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sender_gaps = 1'b1;
    sink_mode = SINK_RANDOM;
    test_continuation_after_reset();
    test_short_and_exception();
    test_function_code_sweep();
    sink_mode = SINK_PATTERN;
    test_diag_subfunctions();
    test_device_id_walk();
    test_huge_object_overflow();
    test_backpressure();
    test_random_traffic();
    rx_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (err_count == 0 && status_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
